/* src/drc_pkg.sv */
// shared types, constants and status codes of the dirty rectangle coalescer
package drc_pkg;

  localparam int CW = 10;   // coordinate width
  localparam int SW = 11;   // size width

  localparam int DEF_SCREEN_WIDTH  = 240;
  localparam int DEF_SCREEN_HEIGHT = 320;
  localparam int DEF_MAX_REGIONS   = 16;
  localparam int DEF_MIN_SPAN      = 16;

  localparam int RESULT_CAP = 16;
  localparam int RELW       = 5;

  localparam logic [15:0] MIN_AGE_RESET = 16'd100;
  localparam logic [7:0]  FULL_RESET    = 8'd10;

  localparam logic CFG_MIN_AGE = 1'b0;
  localparam logic CFG_FULL    = 1'b1;

  localparam logic [2:0] ST_MERGED   = 3'd0;
  localparam logic [2:0] ST_APPENDED = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_RELEASED = 3'd3;
  localparam logic [2:0] ST_NONE     = 3'd4;

  typedef struct packed {
    logic [CW-1:0] left;
    logic [CW-1:0] top;
    logic [SW-1:0] w;
    logic [SW-1:0] h;
    logic [31:0]   born;
    logic [7:0]    merges;
  } region_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic append;
  } cell_ctrl_t;

endpackage

/* src/drc_cell.sv */
// one table slot of the region queue, shifting toward the head
module drc_cell
  import drc_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  region_t    nbr,
  input  region_t    push_val,
  input  region_t    app_val,
  output region_t    entry
);

  always_ff @(posedge clk) begin
    if (ctrl.append) begin
      entry <= app_val;
    end else if (ctrl.load) begin
      entry <= push_val;
    end else if (ctrl.shift) begin
      entry <= nbr;
    end
  end

endmodule

/* src/dirty_rectangle_coalescer_core.sv */
// dirty rectangle coalescer: region queue of cells and its walk sequencer
//
// Input stream s_axis: tuser is the opcode (0 insert, 1 drain), tdata carries
// the rectangle corners and the time. Output stream m_axis: tuser is the
// status, tdata the released region, tlast marks the final result of an item.
// Config channel cfg_*: index 0 is min_age_ms, index 1 is full_after_merges.
//
// Regions sit in a row of cells used as a queue, head in cell 0. Each item
// walks the queue once: every cycle, unless a stalled receiver holds the walk,
// the head is popped, examined and either pushed back at the tail of the queue
// or released. An insert passes through clamp and align, growth, a walk step
// per stored region, a closing step and the issue of its registered result;
// a drain has only the walk, the closing step and the issue. The next item is
// taken the cycle after the final result has moved into the output register;
// no new item is accepted while one is still in progress.
// A release waits in a holding register until the next release or the end of
// the walk decides its tlast; a stalled receiver halts the walk at that point.
// Reset empties the table and restores the register defaults; no clearing
// pass is needed.
module dirty_rectangle_coalescer_core
  import drc_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  parameter int MAX_REGIONS   = DEF_MAX_REGIONS,
  parameter int MIN_SPAN      = DEF_MIN_SPAN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic        s_axis_tuser,   // opcode
  input  logic [95:0] s_axis_tdata,   // left_x, top_y, right_x, bottom_y, now_ms
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [2:0]  m_axis_tuser,   // status
  output logic [47:0] m_axis_tdata,   // region_x, region_y, region_width,
                                      // region_height, redraw_all
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CNTW = $clog2(MAX_REGIONS + 1);
  localparam logic [CW-1:0] XMAX = CW'(SCREEN_WIDTH - 1);
  localparam logic [CW-1:0] YMAX = CW'(SCREEN_HEIGHT - 1);

  typedef enum logic [2:0] {S_IDLE, S_CLAMP, S_GROW, S_WALK, S_DONE} state_t;

  state_t state;
  logic [15:0] min_age;
  logic [7:0]  full_after;
  logic        op;
  logic [15:0] in_l, in_t, in_r, in_b;
  logic [31:0] now;
  logic [CW-1:0] x1, x2, y1, y2;
  logic [CNTW-1:0] count, len, k;
  logic        hit;
  logic [RELW-1:0] nrel;
  logic        pend_valid;
  region_t     pend;
  logic        pend_full;

  logic        out_valid;
  logic [2:0]  out_status;
  region_t     out_reg;
  logic        out_full;
  logic        out_last;

  region_t     cells [MAX_REGIONS];
  region_t     head, merged, push_val, app_val;
  logic        step, push, app, out_load;

  // clamp a signed coordinate into [0, hi]
  function automatic logic [CW-1:0] clampc(input logic [15:0] v, input logic [CW-1:0] hi);
    logic signed [16:0] sv;
    sv = {v[15], v};
    if (sv < 17'sd0) return '0;
    if (sv > $signed({7'd0, hi})) return hi;
    return v[CW-1:0];
  endfunction

  // clamp and align stage
  logic [CW-1:0] cx1, cx2, cy1, cy2, ax2;
  always_comb begin
    cx1 = clampc(in_l, XMAX);
    cx2 = clampc(in_r, XMAX);
    cy1 = clampc(in_t, YMAX);
    cy2 = clampc(in_b, YMAX);
    if (cx1 > cx2) cx1 = cx2;
    if (cy1 > cy2) cy1 = cy2;
    ax2 = {cx2[CW-1:3], 3'b111};
    if (ax2 > XMAX) ax2 = XMAX;
  end

  // growth stage
  logic [CW-1:0] gx1, gx2, gy1, gy2;
  logic [SW-1:0] spx, spy, ex, ey;
  logic [SW:0]   sbx, sby;
  always_comb begin
    gx1 = x1;
    gx2 = x2;
    gy1 = y1;
    gy2 = y2;
    spx = SW'({1'b0, x2} - {1'b0, x1} + 11'd1);
    spy = SW'({1'b0, y2} - {1'b0, y1} + 11'd1);
    ex  = SW'((SW'(MIN_SPAN) - spx) >> 1);
    ey  = SW'((SW'(MIN_SPAN) - spy) >> 1);
    sbx = {2'b0, x2} + {1'b0, ex};
    sby = {2'b0, y2} + {1'b0, ey};
    if (spx < SW'(MIN_SPAN)) begin
      gx1 = ({1'b0, x1} < ex) ? '0 : CW'({1'b0, x1} - ex);
      gx2 = (sbx > {2'b0, XMAX}) ? XMAX : CW'(sbx);
    end
    if (spy < SW'(MIN_SPAN)) begin
      gy1 = ({1'b0, y1} < ey) ? '0 : CW'({1'b0, y1} - ey);
      gy2 = (sby > {2'b0, YMAX}) ? YMAX : CW'(sby);
    end
  end

  // head examination: overlap, merge, age
  logic [SW:0] rxe, rye, nx2, ny2, hx2, hy2;
  logic [CW-1:0] nx1, ny1;
  logic        ovl, aged, rel, full_flag, out_free;
  always_comb begin
    head = cells[0];
    rxe  = {1'b0, head.w} + {2'b0, head.left};
    rye  = {1'b0, head.h} + {2'b0, head.top};
    ovl  = ({2'b0, x1} <= rxe) && (x2 >= head.left) &&
           ({2'b0, y1} <= rye) && (y2 >= head.top);
    nx1  = (head.left < x1) ? head.left : x1;
    ny1  = (head.top < y1) ? head.top : y1;
    hx2  = rxe - 12'd1;
    hy2  = rye - 12'd1;
    nx2  = (hx2 > {2'b0, x2}) ? hx2 : {2'b0, x2};
    ny2  = (hy2 > {2'b0, y2}) ? hy2 : {2'b0, y2};
    merged        = head;
    merged.left   = nx1;
    merged.top    = ny1;
    merged.w      = SW'(nx2 - {2'b0, nx1} + 12'd1);
    merged.h      = SW'(ny2 - {2'b0, ny1} + 12'd1);
    merged.merges = (head.merges == 8'hff) ? head.merges : head.merges + 8'd1;
    aged      = (now - head.born) >= {16'd0, min_age};
    full_flag = head.merges > full_after;
    rel       = op && aged && (nrel < RELW'(RESULT_CAP));
    out_free  = !out_valid || m_axis_tready;

    app_val        = '0;
    app_val.left   = x1;
    app_val.top    = y1;
    app_val.w      = SW'({1'b0, x2} - {1'b0, x1} + 11'd1);
    app_val.h      = SW'({1'b0, y2} - {1'b0, y1} + 11'd1);
    app_val.born   = now;
    app_val.merges = 8'd1;

    push_val = (!op && !hit && ovl) ? merged : head;
    step = (state == S_WALK) && (k != count) && (!rel || !pend_valid || out_free);
    push = step && !rel;
    app  = (state == S_DONE) && out_free && !op && !hit && (count < CNTW'(MAX_REGIONS));
    out_load = (step && rel && pend_valid) || ((state == S_DONE) && out_free);
  end

  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    cell_ctrl_t ctrl;
    region_t    nbr;
    assign ctrl.shift  = step;
    assign ctrl.load   = push && (len == CNTW'(i + 1));
    assign ctrl.append = app && (count == CNTW'(i));
    if (i == MAX_REGIONS - 1) begin : g_tail
      assign nbr = cells[i];
    end else begin : g_mid
      assign nbr = cells[i + 1];
    end
    drc_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .nbr      (nbr),
      .push_val (push_val),
      .app_val  (app_val),
      .entry    (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      min_age    <= MIN_AGE_RESET;
      full_after <= FULL_RESET;
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MIN_AGE: min_age <= cfg_data;
          CFG_FULL:    full_after <= cfg_data[7:0];
          default:     ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op    <= s_axis_tuser;
            in_l  <= s_axis_tdata[15:0];
            in_t  <= s_axis_tdata[31:16];
            in_r  <= s_axis_tdata[47:32];
            in_b  <= s_axis_tdata[63:48];
            now   <= s_axis_tdata[95:64];
            k     <= '0;
            len   <= count;
            hit   <= 1'b0;
            nrel  <= '0;
            state <= s_axis_tuser ? S_WALK : S_CLAMP;
          end
        end
        S_CLAMP: begin
          x1    <= {cx1[CW-1:3], 3'b000};
          x2    <= ax2;
          y1    <= cy1;
          y2    <= cy2;
          state <= S_GROW;
        end
        S_GROW: begin
          x1    <= gx1;
          x2    <= gx2;
          y1    <= gy1;
          y2    <= gy2;
          state <= S_WALK;
        end
        S_WALK: begin
          if (k == count) begin
            state <= S_DONE;
          end else if (step) begin
            k <= k + 1'b1;
            if (!op) hit <= hit | ovl;
            if (rel) begin
              pend       <= head;
              pend_full  <= full_flag;
              pend_valid <= 1'b1;
              nrel       <= nrel + 1'b1;
              len        <= len - 1'b1;
              if (pend_valid) begin
                out_status <= ST_RELEASED;
                out_reg    <= pend;
                out_full   <= pend_full;
                out_last   <= 1'b0;
              end
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_last  <= 1'b1;
            state     <= S_IDLE;
            if (op && pend_valid) begin
              out_reg  <= pend;
              out_full <= pend_full;
            end else begin
              out_reg  <= '0;
              out_full <= 1'b0;
            end
            if (op) begin
              count      <= len;
              pend_valid <= 1'b0;
              out_status <= pend_valid ? ST_RELEASED : ST_NONE;
            end else if (hit) begin
              out_status <= ST_MERGED;
            end else if (app) begin
              out_status <= ST_APPENDED;
              count      <= count + 1'b1;
            end else begin
              out_status <= ST_DROPPED;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {5'd0, out_full, out_reg.h, out_reg.w, out_reg.top, out_reg.left};

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(MAX_REGIONS)) else $error("region count above table size");
  a_walk_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (k <= count && len <= count)) else $error("walk index out of range");
  a_none_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == ST_NONE) |-> m_axis_tlast)
    else $error("empty drain result not last");
  a_pend_rel: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (nrel != '0)) else $error("held release without count");

endmodule

/* dv/tb_dirty_rectangle_coalescer_core.sv */
// testbench of the dirty rectangle coalescer: directed table, random traffic, scoreboard
`timescale 1ns / 1ps

module tb_dirty_rectangle_coalescer_core;
  import drc_pkg::*;

  localparam int SCR_W = 240;
  localparam int SCR_H = 320;
  localparam int SLOTS = 16;
  localparam int SPAN  = 16;
  localparam int N_RANDOM = 190;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  rx;
    logic [9:0]  ry;
    logic [10:0] rw;
    logic [10:0] rh;
    logic        full;
    logic        last;
  } result_t;

  typedef struct {
    logic        drain;
    logic [15:0] x1, y1, x2, y2;
    logic [31:0] now;
    logic        has_exp;
    logic [2:0]  exp_status;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic        s_axis_tuser = 1'b0;
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [2:0]  m_axis_tuser;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_MIN_AGE;
  logic [15:0] cfg_data = '0;

  dirty_rectangle_coalescer_core u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [15:0] min_age;
  logic [7:0]  full_limit;
  int          tbl_x [SLOTS], tbl_y [SLOTS], tbl_w [SLOTS], tbl_h [SLOTS];
  logic [31:0] tbl_born [SLOTS];
  int          tbl_merges [SLOTS];
  int          tbl_count;

  result_t pending_results[$];
  int      errors = 0;
  int      n_results = 0, n_releases = 0, n_items = 0, n_merged = 0, n_dropped = 0;
  longint  cycles = 0;
  bit      stall_heavy = 0;

  function automatic int clip(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic widen(inout int a, inout int b, input int lim);
    int e;
    if (b - a + 1 < SPAN) begin
      e = (SPAN - (b - a + 1)) / 2;
      a = (a - e < 0) ? 0 : a - e;
      b = (b + e > lim - 1) ? lim - 1 : b + e;
    end
  endtask

  function automatic result_t mk(logic [2:0] st, int x, int y, int w, int h,
                                 logic f, logic l);
    result_t r;
    r.status = st; r.rx = 10'(x); r.ry = 10'(y); r.rw = 11'(w); r.rh = 11'(h);
    r.full = f; r.last = l;
    return r;
  endfunction

  task automatic predict_insert(input stim_t s);
    int x1, y1, x2, y2, i, nx1, ny1, nx2, ny2;
    logic [2:0] st;
    x1 = clip(int'($signed(s.x1)), 0, SCR_W - 1);
    x2 = clip(int'($signed(s.x2)), 0, SCR_W - 1);
    y1 = clip(int'($signed(s.y1)), 0, SCR_H - 1);
    y2 = clip(int'($signed(s.y2)), 0, SCR_H - 1);
    if (x1 > x2) x1 = x2;
    if (y1 > y2) y1 = y2;
    x1 = (x1 / 8) * 8;
    x2 = (x2 / 8 + 1) * 8 - 1;
    if (x2 > SCR_W - 1) x2 = SCR_W - 1;
    widen(x1, x2, SCR_W);
    widen(y1, y2, SCR_H);
    st = ST_DROPPED;
    for (i = 0; i < tbl_count; i++) begin
      if (x1 <= tbl_x[i] + tbl_w[i] && x2 >= tbl_x[i] &&
          y1 <= tbl_y[i] + tbl_h[i] && y2 >= tbl_y[i]) begin
        nx1 = tbl_x[i] < x1 ? tbl_x[i] : x1;
        ny1 = tbl_y[i] < y1 ? tbl_y[i] : y1;
        nx2 = tbl_x[i] + tbl_w[i] - 1 > x2 ? tbl_x[i] + tbl_w[i] - 1 : x2;
        ny2 = tbl_y[i] + tbl_h[i] - 1 > y2 ? tbl_y[i] + tbl_h[i] - 1 : y2;
        tbl_x[i] = nx1; tbl_y[i] = ny1;
        tbl_w[i] = nx2 - nx1 + 1; tbl_h[i] = ny2 - ny1 + 1;
        if (tbl_merges[i] < 255) tbl_merges[i]++;
        st = ST_MERGED;
        n_merged++;
        break;
      end
    end
    if (st != ST_MERGED && tbl_count < SLOTS) begin
      tbl_x[tbl_count] = x1; tbl_y[tbl_count] = y1;
      tbl_w[tbl_count] = x2 - x1 + 1; tbl_h[tbl_count] = y2 - y1 + 1;
      tbl_born[tbl_count] = s.now; tbl_merges[tbl_count] = 1;
      tbl_count++;
      st = ST_APPENDED;
    end
    if (st == ST_DROPPED) n_dropped++;
    if (s.has_exp && s.exp_status != st) begin
      $display("%0t: directed row status expected %0d, predictor gives %0d",
               $time, s.exp_status, st);
      errors++;
    end
    pending_results.push_back(mk(st, 0, 0, 0, 0, 1'b0, 1'b1));
  endtask

  task automatic predict_drain(input stim_t s);
    int r, keep, n;
    logic [31:0] age;
    keep = 0; n = 0;
    for (r = 0; r < tbl_count; r++) begin
      age = s.now - tbl_born[r];
      if (n < RESULT_CAP && age >= {16'd0, min_age}) begin
        pending_results.push_back(mk(ST_RELEASED, tbl_x[r], tbl_y[r], tbl_w[r], tbl_h[r],
                                     tbl_merges[r] > full_limit, 1'b0));
        n++;
      end else begin
        tbl_x[keep] = tbl_x[r]; tbl_y[keep] = tbl_y[r];
        tbl_w[keep] = tbl_w[r]; tbl_h[keep] = tbl_h[r];
        tbl_born[keep] = tbl_born[r]; tbl_merges[keep] = tbl_merges[r];
        keep++;
      end
    end
    tbl_count = keep;
    if (n == 0) pending_results.push_back(mk(ST_NONE, 0, 0, 0, 0, 1'b0, 1'b1));
    else pending_results[pending_results.size() - 1].last = 1'b1;
    if (s.has_exp && ((n == 0) != (s.exp_status == ST_NONE))) begin
      $display("%0t: directed drain expected status %0d, predictor gives %0d releases",
               $time, s.exp_status, n);
      errors++;
    end
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // output side: random stalls and cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      m_axis_tready <= stall_heavy ? ($urandom_range(0, 9) == 0) :
                       ($urandom_range(0, 3) != 0);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // scoreboard: handshake lines are stable from here to the next rising edge
  always @(negedge clk) begin
    result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tuser;
      {got.full, got.rh, got.rw, got.ry, got.rx} = m_axis_tdata[42:0];
      got.last = m_axis_tlast;
      n_results++;
      if (got.status == ST_RELEASED) n_releases++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d", $time, got.status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected st=%0d x=%0d y=%0d w=%0d h=%0d f=%0d l=%0d",
                   $time, want.status, want.rx, want.ry, want.rw, want.rh, want.full,
                   want.last);
          $display("%0t:          actual st=%0d x=%0d y=%0d w=%0d h=%0d f=%0d l=%0d",
                   $time, got.status, got.rx, got.ry, got.rw, got.rh, got.full,
                   got.last);
          errors++;
        end
        if (m_axis_tdata[47:43] !== '0) begin
          $display("%0t: tdata pad expected 0, actual %h", $time, m_axis_tdata[47:43]);
          errors++;
        end
      end
    end
  end

  task automatic send(input stim_t s);
    int g;
    bit rdy;
    g = gap_len();
    repeat (g) @(posedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= s.drain;
    s_axis_tdata  <= {s.now, s.y2, s.x2, s.y1, s.x1};
    do begin
      @(negedge clk);
      rdy = s_axis_tready;
      @(posedge clk);
    end while (!rdy);
    if (s.drain) predict_drain(s);
    else predict_insert(s);
    n_items++;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_MIN_AGE) min_age = val;
    else full_limit = val[7:0];
    @(posedge clk);
  endtask

  function automatic stim_t ins(int x1, int y1, int x2, int y2, logic [31:0] t,
                                bit he = 0, logic [2:0] es = ST_MERGED);
    stim_t s;
    s.drain = 0; s.x1 = 16'(x1); s.y1 = 16'(y1); s.x2 = 16'(x2); s.y2 = 16'(y2);
    s.now = t;
    s.has_exp = he; s.exp_status = es;
    return s;
  endfunction

  function automatic stim_t drn(logic [31:0] t, bit he = 0, logic [2:0] es = ST_NONE);
    stim_t s;
    s = ins(0, 0, 0, 0, t, he, es);
    s.drain = 1;
    s.x1 = 16'($urandom); s.y1 = 16'($urandom);
    s.x2 = 16'($urandom); s.y2 = 16'($urandom);
    return s;
  endfunction

  function automatic stim_t rand_ins(logic [31:0] t);
    int x, y;
    if ($urandom_range(0, 9) == 0)
      return ins($urandom, $urandom, $urandom, $urandom, t);
    x = $urandom_range(0, SCR_W + 20) - 10;
    y = $urandom_range(0, SCR_H + 20) - 10;
    return ins(x, y, x + $urandom_range(0, 40) - 4, y + $urandom_range(0, 40) - 4, t);
  endfunction

  stim_t directed[$];
  logic [31:0] clock_ms;

  initial begin
    int i, k;
    min_age = MIN_AGE_RESET;
    full_limit = FULL_RESET;
    tbl_count = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset defaults, extremes, wrap, inverted, merges
    directed.push_back(drn(32'd0, 1, ST_NONE));
    directed.push_back(ins(-32768, -32768, -32768, -32768, 32'd0, 1, ST_APPENDED));
    directed.push_back(ins(32767, 32767, 32767, 32767, 32'd5, 1, ST_APPENDED));
    directed.push_back(ins(100, 100, 50, 40, 32'd5, 1, ST_APPENDED));
    directed.push_back(ins(17, 17, 17, 17, 32'd6, 1, ST_APPENDED));
    directed.push_back(ins(233, 150, 239, 152, 32'd7));
    directed.push_back(ins(-1, 300, 32767, 32767, 32'd8));
    directed.push_back(drn(32'd99, 1, ST_NONE));
    directed.push_back(drn(32'd105));
    directed.push_back(ins(120, 200, 127, 215, 32'hFFFF_FFF0));
    directed.push_back(ins(144, 200, 151, 215, 32'hFFFF_FFF0));
    directed.push_back(drn(32'h0000_0060));
    directed.push_back(drn(32'h0000_0080));
    directed.push_back(drn(32'hFFFF_FFFF));
    foreach (directed[j]) send(directed[j]);
    wait_idle();

    // extremes of both registers and a table filled past capacity
    write_reg(CFG_MIN_AGE, 16'd0);
    write_reg(CFG_FULL, 16'd0);
    send(drn(32'd0));
    for (i = 0; i < 18; i++)
      send(ins((i % 8) * 30, (i / 8) * 120, (i % 8) * 30, (i / 8) * 120 + 1, i));
    send(drn(32'd1000));
    wait_idle();
    write_reg(CFG_MIN_AGE, 16'hFFFF);
    write_reg(CFG_FULL, 16'h00FF);
    for (i = 0; i < 3; i++) send(ins(-1, -1, 0, 0, 32'd0));
    send(drn(32'd65534));
    send(drn(32'd65535));
    wait_idle();

    // random phases with varied settings
    clock_ms = $urandom;
    for (k = 0; k < 5; k++) begin
      write_reg(CFG_MIN_AGE, k == 4 ? 16'hFFFF : 16'($urandom_range(0, 300)));
      write_reg(CFG_FULL, k == 3 ? 16'd255 : 16'($urandom_range(0, 12)));
      stall_heavy = (k == 2);
      for (i = 0; i < N_RANDOM / 5; i++) begin
        clock_ms = clock_ms + $urandom_range(0, 60);
        if ($urandom_range(0, 5) == 0) send(drn(k == 4 ? clock_ms + 32'h1_0000 : clock_ms));
        else send(rand_ins(clock_ms));
        if (i == 20) wait_idle();
      end
      send(drn(clock_ms + 32'h1_0000));
      wait_idle();
    end

    $display("%0d items, %0d results (%0d releases, %0d merges, %0d drops)",
             n_items, n_results, n_releases, n_merged, n_dropped);
    $display("register extremes, time wrap, full table and receiver stalls exercised");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* dirty_rectangle_coalescer_core.f */
src/drc_pkg.sv
src/drc_cell.sv
src/dirty_rectangle_coalescer_core.sv
dv/tb_dirty_rectangle_coalescer_core.sv
